// File: sv/fpsqrt_pkg.sv
// ----------------------------------------------------------------------------
// fpsqrt_pkg
// Shared types and constants for the fixed-point square root unit.
// ----------------------------------------------------------------------------
package fpsqrt_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FRAC_W = 5;

  localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd16;
  localparam logic [FRAC_W-1:0] MID_FRAC   = 5'd16;

  localparam logic [DATA_W-1:0] PHASE1_BIT = 32'h4000_0000;
  localparam logic [DATA_W-1:0] PHASE2_BIT = 32'h0000_4000;
  localparam logic [DATA_W-1:0] REM_LIMIT  = 32'h0000_FFFF;
  localparam logic [DATA_W-1:0] HALF_STEP  = 32'h0000_8000;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PH1  = 5'b00010,
    S_MID  = 5'b00100,
    S_PH2  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  typedef struct packed {
    logic load_in;
    logic iterate;
    logic mid;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_step;
  } status_t;

endpackage

// File: sv/fixed_point_square_root.sv
// ----------------------------------------------------------------------------
// fixed_point_square_root
// Signed fixed-point square root with a programmable fraction width.
//
//   channel   dir  handshake             payload
//   in_       in   in_tvalid/in_tready   in_tdata[31:0]  value
//   out_      out  out_tvalid/out_tready out_tdata[31:0] root
//   cfg_      in   cfg_valid/cfg_ready   cfg_data[4:0]   frac_bits
//
// an item is accepted and scaled, then takes 16 first-phase root steps,
// one fold step and 8 second-phase steps, and is then rounded and loaded
// into the output register; both phases share the one-bit-per-cycle root step.
// reset sets frac_bits to 16 and empties the output register.
// a stalled result holds in the output register while the next item is
// accepted; the last step waits only if that register is still full.
// ----------------------------------------------------------------------------
module fixed_point_square_root (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // root
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // frac_bits
);
  import fpsqrt_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  fpsqrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  fpsqrt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_write (cfg_valid),
    .cfg_frac  (cfg_data),
    .in_value  (in_tdata),
    .out_root  (out_tdata)
  );

endmodule

// File: sv/fpsqrt_dp.sv
// ----------------------------------------------------------------------------
// fpsqrt_dp
// Datapath: operand scaling, restoring root step, half-step fold and
// final rounding, rescale and sign.
// ----------------------------------------------------------------------------
module fpsqrt_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fpsqrt_pkg::cmd_t              cmd,
  output fpsqrt_pkg::status_t           status,
  input  logic                          cfg_write,
  input  logic [fpsqrt_pkg::FRAC_W-1:0] cfg_frac,
  input  logic [fpsqrt_pkg::DATA_W-1:0] in_value,
  output logic [fpsqrt_pkg::DATA_W-1:0] out_root
);
  import fpsqrt_pkg::*;

  logic [FRAC_W-1:0] frac_bits_r, frac_bits_nxt;
  logic [DATA_W-1:0] num_r, num_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic [DATA_W-1:0] bit_r, bit_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] root_r, root_nxt;

  logic [DATA_W-1:0] mag;
  logic [FRAC_W-1:0] sh_up;
  logic [FRAC_W-1:0] sh_dn;
  logic [DATA_W-1:0] trial;
  logic [DATA_W-1:0] rounded;
  logic [DATA_W-1:0] scaled;

  always_comb begin
    frac_bits_nxt = cfg_write ? cfg_frac : frac_bits_r;
  end

  always_comb begin
    mag     = in_value[DATA_W-1] ? (~in_value + 32'd1) : in_value;
    sh_up   = MID_FRAC - frac_bits_r;
    sh_dn   = frac_bits_r - MID_FRAC;
    trial   = res_r + bit_r;
    rounded = res_r + {31'd0, (num_r > res_r)};
    if (frac_bits_r < MID_FRAC) begin
      scaled = rounded >> sh_up;
    end else begin
      scaled = rounded << sh_dn;
    end

    num_nxt  = num_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    neg_nxt  = neg_r;
    root_nxt = root_r;

    if (cmd.load_in) begin
      neg_nxt = in_value[DATA_W-1];
      res_nxt = '0;
      bit_nxt = PHASE1_BIT;
      if (frac_bits_r < MID_FRAC) begin
        num_nxt = mag << sh_up;
      end else begin
        num_nxt = mag >> sh_dn;
      end
    end else if (cmd.iterate) begin
      if (num_r >= trial) begin
        num_nxt = num_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
    end else if (cmd.mid) begin
      bit_nxt = PHASE2_BIT;
      if (num_r > REM_LIMIT) begin
        num_nxt = ((num_r - res_r) << 16) - HALF_STEP;
        res_nxt = (res_r << 16) + HALF_STEP;
      end else begin
        num_nxt = num_r << 16;
        res_nxt = res_r << 16;
      end
    end

    if (cmd.finish) begin
      root_nxt = neg_r ? (~scaled + 32'd1) : scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_bits_r <= FRAC_RESET;
    end else begin
      frac_bits_r <= frac_bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    neg_r  <= neg_nxt;
    root_r <= root_nxt;
  end

  assign status.last_step = bit_r[0];
  assign out_root         = root_r;

endmodule

// File: sv/fpsqrt_ctrl.sv
// ----------------------------------------------------------------------------
// fpsqrt_ctrl
// Controller: sequences load, two root phases, fold step and result load,
// and owns the handshake state of both streams.
// ----------------------------------------------------------------------------
module fpsqrt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  fpsqrt_pkg::status_t status,
  output fpsqrt_pkg::cmd_t    cmd
);
  import fpsqrt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_PH1;
        end
      end
      S_PH1: begin
        cmd.iterate = 1'b1;
        if (status.last_step) begin
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        cmd.mid   = 1'b1;
        state_nxt = S_PH2;
      end
      S_PH2: begin
        cmd.iterate = 1'b1;
        if (status.last_step) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-point square root unit. A short table of
// operands covers zero, one, the signed extremes and the fraction widths at
// both ends. Over a thousand random operands then run under a range of
// fraction widths while both stream sides idle and stall. Each root is
// compared in order with a known table root or a bit-exact bench model.
// ----------------------------------------------------------------------------
module tb;
  import fpsqrt_pkg::*;

  localparam logic [DATA_W-1:0] TOP_MASK      = 32'hFFF0_0000;
  localparam logic [DATA_W-1:0] LOW_START_BIT = 32'h0004_0000;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_AT      = 530;
  localparam int unsigned SETTLE       = 30;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 96;
  localparam int unsigned DIR_N        = 22;

  typedef struct packed {
    logic [FRAC_W-1:0] fb;
    logic [DATA_W-1:0] value;
    logic              known;
    logic [DATA_W-1:0] root;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [31:0]       in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [31:0]       out_tdata;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [4:0]        cfg_data;

  logic [DATA_W-1:0] expected_roots[$];
  logic [FRAC_W-1:0] frac_mirror;
  logic [FRAC_W-1:0] frac_now;
  logic              req_known;
  logic [DATA_W-1:0] req_root;
  dir_row_t          directed_rows [DIR_N];
  int unsigned       send_pct;
  int unsigned       recv_pct;
  int unsigned       hold_left;
  bit                hold_done;
  int unsigned       requests_in;
  int unsigned       roots_checked;
  int unsigned       cfg_writes;
  int unsigned       idle_cycles;
  int unsigned       error_count;

  fixed_point_square_root uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // value
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // root
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)    // frac_bits
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void restore_steps(inout logic [DATA_W-1:0] rem,
                                        inout logic [DATA_W-1:0] res,
                                        input logic [DATA_W-1:0] step_bit);
    logic [DATA_W-1:0] trial;
    logic [DATA_W-1:0] b;
    b = step_bit;
    while (b != 0) begin
      trial = res + b;
      if (rem >= trial) begin
        rem = rem - trial;
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
  endfunction

  function automatic logic [DATA_W-1:0] predict_root(input logic [DATA_W-1:0] v,
                                                     input logic [FRAC_W-1:0] fb);
    logic              neg;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] step_bit;
    int                sh;
    neg = v[DATA_W-1];
    mag = neg ? (32'd0 - v) : v;
    sh  = int'(fb) - int'(MID_FRAC);
    if (sh < 0) mag = mag << (-sh);
    else mag = mag >> sh;
    step_bit = ((mag & TOP_MASK) != 0) ? PHASE1_BIT : LOW_START_BIT;
    while (step_bit > mag) step_bit = step_bit >> 2;
    res = '0;
    restore_steps(mag, res, step_bit);
    if (mag > REM_LIMIT) begin
      mag = mag - res;
      mag = (mag << 16) - HALF_STEP;
      res = (res << 16) + HALF_STEP;
    end else begin
      mag = mag << 16;
      res = res << 16;
    end
    restore_steps(mag, res, PHASE2_BIT);
    if (mag > res) res = res + 1;
    if (sh < 0) res = res >> (-sh);
    else res = res << sh;
    return neg ? (32'd0 - res) : res;
  endfunction

  function automatic logic [DATA_W-1:0] random_operand();
    logic [DATA_W-1:0] r;
    int unsigned       k;
    case ($urandom_range(5))
      0: r = $urandom;
      1: r = $urandom >> $urandom_range(31);
      2: r = 32'd0 - ($urandom >> $urandom_range(31));
      3: begin
        k = $urandom_range(65535);
        r = k * k;
      end
      4: begin
        case ($urandom_range(4))
          0: r = 32'h8000_0000;
          1: r = 32'h7FFF_FFFF;
          2: r = 32'h0000_0000;
          3: r = 32'h0000_0001;
          default: r = 32'hFFFF_FFFF;
        endcase
      end
      default: r = $urandom_range(65535) << $urandom_range(16);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("mismatch %0s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // checker: config mirror, expectations, result compare and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        frac_mirror = cfg_data;
        cfg_writes++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected root", out_tdata, 'x);
        end else begin
          if (out_tdata !== expected_roots[0])
            report_mismatch("root", out_tdata, expected_roots[0]);
          void'(expected_roots.pop_front());
        end
        roots_checked++;
      end
      if (in_tvalid && in_tready) begin
        expected_roots.push_back(req_known ? req_root : predict_root(in_tdata, frac_mirror));
        requests_in++;
      end
      if ((cfg_valid && cfg_ready) || (out_tvalid && out_tready) ||
          (in_tvalid && in_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("watchdog: no transfer for %0d cycles", idle_cycles);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off so the unit backs up
  always @(negedge clk) begin
    if (!hold_done && requests_in >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_pct);
    end
  end

  task automatic send_request(input logic [DATA_W-1:0] v, input logic known,
                              input logic [DATA_W-1:0] root);
    while ($urandom_range(99) < send_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = v;
    req_known = known;
    req_root  = root;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (expected_roots.size() != 0) @(negedge clk);
  endtask

  task automatic write_frac(input logic [FRAC_W-1:0] fb);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = fb;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    frac_now  = fb;
  endtask

  initial begin
    logic [FRAC_W-1:0] phase_fb [PHASES];
    int unsigned       pct_send [4];
    int unsigned       pct_recv [4];
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    req_known     = 1'b0;
    req_root      = '0;
    send_pct      = 0;
    recv_pct      = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    requests_in   = 0;
    roots_checked = 0;
    cfg_writes    = 0;
    idle_cycles   = 0;
    error_count   = 0;
    frac_mirror   = FRAC_RESET;
    frac_now      = FRAC_RESET;

    directed_rows = '{
      '{5'd16, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{5'd16, 32'h0001_0000, 1'b1, 32'h0001_0000},
      '{5'd16, 32'hFFFF_0000, 1'b1, 32'hFFFF_0000},
      '{5'd16, 32'h0004_0000, 1'b1, 32'h0002_0000},
      '{5'd16, 32'h0002_0000, 1'b0, 32'h0},
      '{5'd16, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{5'd16, 32'h8000_0000, 1'b0, 32'h0},
      '{5'd16, 32'h0000_0001, 1'b0, 32'h0},
      '{5'd16, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{5'd0,  32'h0000_0000, 1'b1, 32'h0000_0000},
      '{5'd0,  32'h0000_0001, 1'b1, 32'h0000_0001},
      '{5'd0,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{5'd0,  32'h7FFF_FFFF, 1'b0, 32'h0},
      '{5'd0,  32'h0000_FFFF, 1'b0, 32'h0},
      '{5'd0,  32'h8000_0000, 1'b0, 32'h0},
      '{5'd31, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{5'd31, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{5'd31, 32'h8000_0000, 1'b0, 32'h0},
      '{5'd31, 32'h4000_0000, 1'b0, 32'h0},
      '{5'd31, 32'h0000_0001, 1'b0, 32'h0},
      '{5'd24, 32'h0100_0000, 1'b0, 32'h0},
      '{5'd24, 32'hFEFF_FFFF, 1'b0, 32'h0}
    };
    phase_fb = '{5'd0, 5'd31, 5'd16, 5'd8, 5'd24, 5'd1, 5'd15, 5'd17,
                 5'd30, 5'd5, 5'd20, 5'd16};
    phase_fb[PHASES-1] = FRAC_W'($urandom_range(31));
    pct_send = '{0, 54, 0, 22};
    pct_recv = '{0, 0, 54, 22};

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table, checked at the default fraction width first
    for (int i = 0; i < DIR_N; i++) begin
      if (directed_rows[i].fb != frac_now) write_frac(directed_rows[i].fb);
      send_request(directed_rows[i].value, directed_rows[i].known, directed_rows[i].root);
    end

    // random operands, one fraction width and idle pattern per phase
    for (int p = 0; p < PHASES; p++) begin
      write_frac(phase_fb[p]);
      send_pct = pct_send[p % 4];
      recv_pct = pct_recv[p % 4];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 6 && i == PHASE_ITEMS / 2) wait_drained();
        send_request(random_operand(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SETTLE + 10) @(negedge clk);
    $display("summary: %0d operands, %0d roots checked, %0d fraction width writes",
             requests_in, roots_checked, cfg_writes);
    $display("summary: widths 0 to 31, sender and receiver idling, one long receiver hold-off");
    if (error_count == 0 && expected_roots.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("errors: %0d, roots still pending: %0d", error_count, expected_roots.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: fixed_point_square_root.f
sv/fpsqrt_pkg.sv
sv/fpsqrt_dp.sv
sv/fpsqrt_ctrl.sv
sv/fixed_point_square_root.sv
bench/tb.sv
